### hw/rtl/assert_macros.svh
// Assertion helpers included by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vts_pkg.sv
package vts_pkg;

    // Grid and store geometry.
    localparam int MAX_DIM     = 32;
    localparam int DIM_BITS    = 5;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS   = 15;
    localparam int SIZE_BITS   = 6;
    localparam int PLANE_BITS  = 11;

    // Data formats.
    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 17;
    localparam int SCALED_BITS = COORD_BITS + SIZE_BITS;
    localparam int CELL_BITS   = 8;
    localparam int DENS_BITS   = 16;

    // One half in the Q.16 coordinate format.
    localparam logic [SCALED_BITS-1:0] HALF = SCALED_BITS'(32768);

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [SIZE_BITS-1:0]    SIZE_RESET = 6'd32;

    // Corner fetch sequencing: two corners per pair, four pairs per query.
    localparam logic [1:0] PAIR_LAST = 2'd3;

    // Result queue.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int CREDIT_BITS   = 3;

endpackage

### hw/rtl/vts_in_if.sv
interface vts_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [vts_pkg::ADDR_BITS-1:0]       voxel_index;
    logic [vts_pkg::VALUE_BITS-1:0]      voxel_value;
    logic [vts_pkg::COORD_BITS-1:0]      point_x;
    logic [vts_pkg::COORD_BITS-1:0]      point_y;
    logic [vts_pkg::COORD_BITS-1:0]      point_z;

    modport source (
        output valid, operation, voxel_index, voxel_value, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, operation, voxel_index, voxel_value, point_x, point_y, point_z,
        output ready
    );
endinterface

### hw/rtl/vts_out_if.sv
interface vts_out_if;
    logic                           valid;
    logic                           ready;
    logic [vts_pkg::DENS_BITS-1:0]  density_out;

    modport source (output valid, density_out, input ready);
    modport sink (input valid, density_out, output ready);
endinterface

### hw/rtl/vts_cfg_if.sv
interface vts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vts_pkg::CFG_IDX_BITS-1:0]  reg_index;
    logic [vts_pkg::SIZE_BITS-1:0]     write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink (input valid, reg_index, write_data, output ready);
endinterface

### hw/rtl/voxel_trilinear_sampler.sv
// Trilinear voxel sampler. The block holds a 32x32x32 store of 16-bit densities in a
// single synchronous RAM with one write port and two read ports. A write transaction
// stores one voxel in the cycle it is accepted and produces no result; writes can be
// accepted every cycle while no query is fetching corners. A query transaction fetches
// the eight corner voxels as four pairs, one pair per cycle through the two read
// ports, so the block takes no new query before the last one reaches its final pair;
// the two read ports set that limit. A result passes the read and lerp registers and
// waits in a four-entry output queue, so while the output stalls the input side keeps
// running until four queries are in flight or queued. Corners outside the
// configured grid read as zero. The voxel store has no reset value and no clearing
// pass: a voxel must be written before any query reads it. Size registers may only be
// changed while the block is idle; a size of 0 acts as 1 and a size above 32 acts as 32.
`include "assert_macros.svh"

module voxel_trilinear_sampler (
    input  logic     i_clk,
    input  logic     i_rst_n,
    vts_cfg_if.sink  i_cfg,
    vts_in_if.sink   i_in,
    vts_out_if.source o_out
);

    // Linear interpolation a + floor((b - a) * f / 2^FRAC_BITS). The result always
    // lies between a and b, so it fits the value width.
    function automatic logic [vts_pkg::VALUE_BITS-1:0] f_blend(
        input logic [vts_pkg::VALUE_BITS-1:0] a,
        input logic [vts_pkg::VALUE_BITS-1:0] b,
        input logic [vts_pkg::FRAC_BITS-1:0]  f
    );
        logic signed [vts_pkg::VALUE_BITS:0]                      diff;
        logic signed [vts_pkg::VALUE_BITS+vts_pkg::FRAC_BITS+1:0] prod;
        logic signed [vts_pkg::VALUE_BITS:0]                      step;
        logic        [vts_pkg::VALUE_BITS:0]                      sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        step = (vts_pkg::VALUE_BITS+1)'(prod >>> vts_pkg::FRAC_BITS);
        sum  = {1'b0, a} + $unsigned(step);
        return sum[vts_pkg::VALUE_BITS-1:0];
    endfunction

    // Clamp a size register to the usable range.
    function automatic logic [vts_pkg::SIZE_BITS-1:0] f_eff_size(
        input logic [vts_pkg::SIZE_BITS-1:0] v
    );
        logic [vts_pkg::SIZE_BITS-1:0] r;
        if (v == '0) begin
            r = vts_pkg::SIZE_BITS'(1);
        end else if (v > vts_pkg::SIZE_BITS'(vts_pkg::MAX_DIM)) begin
            r = vts_pkg::SIZE_BITS'(vts_pkg::MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Scale a coordinate by the axis size, take away one half and add one cell,
    // so the result is never negative. Cell is the upper part minus one.
    function automatic logic [vts_pkg::SCALED_BITS-1:0] f_scale(
        input logic [vts_pkg::COORD_BITS-1:0] p,
        input logic [vts_pkg::SIZE_BITS-1:0]  n
    );
        return vts_pkg::SCALED_BITS'(p) * vts_pkg::SCALED_BITS'(n) + vts_pkg::HALF;
    endfunction

    function automatic logic [vts_pkg::CELL_BITS-1:0] f_cell(
        input logic [vts_pkg::SCALED_BITS-1:0] t
    );
        return vts_pkg::CELL_BITS'(t[vts_pkg::SCALED_BITS-1:16]) - vts_pkg::CELL_BITS'(1);
    endfunction

    // True when a two's complement cell index lies in 0..n-1.
    function automatic logic f_inside(
        input logic [vts_pkg::CELL_BITS-1:0] c,
        input logic [vts_pkg::SIZE_BITS-1:0] n
    );
        return !c[vts_pkg::CELL_BITS-1] && (c < vts_pkg::CELL_BITS'(n));
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [vts_pkg::SIZE_BITS-1:0] r_size_x;
    logic [vts_pkg::SIZE_BITS-1:0] r_size_y;
    logic [vts_pkg::SIZE_BITS-1:0] r_size_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vts_pkg::SIZE_RESET;
            r_size_y <= vts_pkg::SIZE_RESET;
            r_size_z <= vts_pkg::SIZE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                vts_pkg::REG_SIZE_X: r_size_x <= i_cfg.write_data;
                vts_pkg::REG_SIZE_Y: r_size_y <= i_cfg.write_data;
                vts_pkg::REG_SIZE_Z: r_size_z <= i_cfg.write_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and flow control.
    // ------------------------------------------------------------------
    logic                             r_f_busy;
    logic [1:0]                       r_f_k;
    logic [vts_pkg::CREDIT_BITS-1:0]  r_credit;
    logic                             fetch_free;
    logic                             credit_ok;
    logic                             in_acc;
    logic                             q_acc;
    logic                             w_acc;
    logic                             out_acc;

    // The fetch sequencer is free during its last pair, so queries chain back to
    // back. Credits count queries accepted and not yet delivered, which
    // keeps the output queue from overflowing without stalling the pipeline.
    assign fetch_free = !r_f_busy || (r_f_k == vts_pkg::PAIR_LAST);
    assign credit_ok  = r_credit < vts_pkg::CREDIT_BITS'(vts_pkg::FIFO_DEPTH);
    assign i_in.ready = fetch_free && credit_ok;
    assign in_acc     = i_in.valid && i_in.ready;
    assign q_acc      = in_acc && (i_in.operation == vts_pkg::OP_QUERY);
    assign w_acc      = in_acc && (i_in.operation == vts_pkg::OP_WRITE);

    // ------------------------------------------------------------------
    // Query setup: split each axis into a cell index and a fraction.
    // ------------------------------------------------------------------
    logic [vts_pkg::SIZE_BITS-1:0]   n_nx, n_ny, n_nz;
    logic [vts_pkg::SCALED_BITS-1:0] n_tx, n_ty, n_tz;
    logic [vts_pkg::PLANE_BITS-1:0]  n_plane;

    assign n_nx    = f_eff_size(r_size_x);
    assign n_ny    = f_eff_size(r_size_y);
    assign n_nz    = f_eff_size(r_size_z);
    assign n_tx    = f_scale(i_in.point_x, n_nx);
    assign n_ty    = f_scale(i_in.point_y, n_ny);
    assign n_tz    = f_scale(i_in.point_z, n_nz);
    assign n_plane = vts_pkg::PLANE_BITS'(n_nx) * vts_pkg::PLANE_BITS'(n_ny);

    logic [vts_pkg::CELL_BITS-1:0]  r_f_cx, r_f_cy, r_f_cz;
    logic [vts_pkg::FRAC_BITS-1:0]  r_f_fx, r_f_fy, r_f_fz;
    logic [vts_pkg::SIZE_BITS-1:0]  r_f_nx, r_f_ny, r_f_nz;
    logic [vts_pkg::PLANE_BITS-1:0] r_f_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_busy <= 1'b0;
            r_f_k    <= '0;
        end else if (q_acc) begin
            r_f_busy <= 1'b1;
            r_f_k    <= '0;
        end else if (r_f_busy) begin
            if (r_f_k == vts_pkg::PAIR_LAST) begin
                r_f_busy <= 1'b0;
            end
            r_f_k <= r_f_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_acc) begin
            r_f_cx    <= f_cell(n_tx);
            r_f_cy    <= f_cell(n_ty);
            r_f_cz    <= f_cell(n_tz);
            r_f_fx    <= n_tx[vts_pkg::FRAC_BITS-1:0];
            r_f_fy    <= n_ty[vts_pkg::FRAC_BITS-1:0];
            r_f_fz    <= n_tz[vts_pkg::FRAC_BITS-1:0];
            r_f_nx    <= n_nx;
            r_f_ny    <= n_ny;
            r_f_nz    <= n_nz;
            r_f_plane <= n_plane;
        end
    end

    // ------------------------------------------------------------------
    // Corner fetch: pair k covers dy = k[0], dz = k[1] and both x corners.
    // ------------------------------------------------------------------
    logic [vts_pkg::CELL_BITS-1:0] yy, zz, x1;
    logic                          in_yz, in0, in1;
    logic [vts_pkg::ADDR_BITS-1:0] base, addr0, addr1;

    assign yy    = r_f_cy + vts_pkg::CELL_BITS'(r_f_k[0]);
    assign zz    = r_f_cz + vts_pkg::CELL_BITS'(r_f_k[1]);
    assign x1    = r_f_cx + vts_pkg::CELL_BITS'(1);
    assign in_yz = f_inside(yy, r_f_ny) && f_inside(zz, r_f_nz);
    assign in0   = in_yz && f_inside(r_f_cx, r_f_nx);
    assign in1   = in_yz && f_inside(x1, r_f_nx);

    // The address only matters for corners inside the grid, where every
    // coordinate fits the low index bits and the sum stays inside the store.
    assign base  = vts_pkg::ADDR_BITS'(vts_pkg::ADDR_BITS'(zz[vts_pkg::DIM_BITS-1:0])
                       * vts_pkg::ADDR_BITS'(r_f_plane))
                 + vts_pkg::ADDR_BITS'(vts_pkg::ADDR_BITS'(yy[vts_pkg::DIM_BITS-1:0])
                       * vts_pkg::ADDR_BITS'(r_f_nx));
    assign addr0 = base + vts_pkg::ADDR_BITS'(r_f_cx[vts_pkg::DIM_BITS-1:0]);
    assign addr1 = base + vts_pkg::ADDR_BITS'(x1[vts_pkg::DIM_BITS-1:0]);

    // Voxel store. A read in the same cycle as a write to the same entry sees the
    // old value, which matches transaction order: the query came first.
    logic [vts_pkg::VALUE_BITS-1:0] r_mem [vts_pkg::STORE_DEPTH];
    logic [vts_pkg::VALUE_BITS-1:0] r_rd0, r_rd1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[i_in.voxel_index] <= i_in.voxel_value;
        end
        r_rd0 <= r_mem[addr0];
        r_rd1 <= r_mem[addr1];
    end

    // Side information that travels with each pair read.
    logic                          r_m_valid;
    logic [1:0]                    r_m_k;
    logic                          r_m_in0, r_m_in1;
    logic [vts_pkg::FRAC_BITS-1:0] r_m_fx, r_m_fy, r_m_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_f_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_k   <= r_f_k;
        r_m_in0 <= in0;
        r_m_in1 <= in1;
        r_m_fx  <= r_f_fx;
        r_m_fy  <= r_f_fy;
        r_m_fz  <= r_f_fz;
    end

    // ------------------------------------------------------------------
    // Blend tree: x lerp per pair, then two y lerps, then the z lerp.
    // ------------------------------------------------------------------
    logic [vts_pkg::VALUE_BITS-1:0] v0, v1;
    logic [vts_pkg::VALUE_BITS-1:0] r_c [4];
    logic                           r_b_last;
    logic [vts_pkg::FRAC_BITS-1:0]  r_b_fy, r_b_fz;

    assign v0 = r_m_in0 ? r_rd0 : '0;
    assign v1 = r_m_in1 ? r_rd1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_last <= 1'b0;
        end else begin
            r_b_last <= r_m_valid && (r_m_k == vts_pkg::PAIR_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_valid) begin
            r_c[r_m_k] <= f_blend(v0, v1, r_m_fx);
        end
        r_b_fy <= r_m_fy;
        r_b_fz <= r_m_fz;
    end

    logic                           r_c_valid;
    logic [vts_pkg::VALUE_BITS-1:0] r_c0, r_c1;
    logic [vts_pkg::FRAC_BITS-1:0]  r_c_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0   <= f_blend(r_c[0], r_c[1], r_b_fy);
        r_c1   <= f_blend(r_c[2], r_c[3], r_b_fy);
        r_c_fz <= r_b_fz;
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    logic [vts_pkg::DENS_BITS-1:0]     r_fifo [vts_pkg::FIFO_DEPTH];
    logic [vts_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [vts_pkg::CREDIT_BITS-1:0]   r_fifo_cnt;

    assign o_out.valid       = (r_fifo_cnt != '0);
    assign o_out.density_out = r_fifo[r_rd_ptr];
    assign out_acc           = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_fifo[r_wr_ptr] <= vts_pkg::DENS_BITS'(f_blend(r_c0, r_c1, r_c_fz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (r_c_valid) begin
                r_wr_ptr <= r_wr_ptr + vts_pkg::FIFO_PTR_BITS'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + vts_pkg::FIFO_PTR_BITS'(1);
            end
            case ({r_c_valid, out_acc})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + vts_pkg::CREDIT_BITS'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - vts_pkg::CREDIT_BITS'(1);
                default: ;
            endcase
            case ({q_acc, out_acc})
                2'b10:   r_credit <= r_credit + vts_pkg::CREDIT_BITS'(1);
                2'b01:   r_credit <= r_credit - vts_pkg::CREDIT_BITS'(1);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_credit_bound, i_clk, i_rst_n, 1'b1,
        r_credit <= vts_pkg::CREDIT_BITS'(vts_pkg::FIFO_DEPTH), "credit count overflow")
    `ASSERT_SAME(a_queue_in_credit, i_clk, i_rst_n, 1'b1,
        r_fifo_cnt <= r_credit, "queued results exceed outstanding queries")
    `ASSERT_NEXT(a_query_starts_fetch, i_clk, i_rst_n, q_acc,
        r_f_busy && (r_f_k == '0), "query did not start its corner fetch")
    `ASSERT_SAME(a_write_not_mid_fetch, i_clk, i_rst_n, w_acc,
        !r_f_busy || (r_f_k == vts_pkg::PAIR_LAST), "write overtook pending corner reads")

endmodule

### verif/voxel_trilinear_sampler_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the trilinear voxel sampler.
//
// The bench keeps a shadow copy of the voxel store and of the three size
// registers. Every transaction the block accepts is applied to that copy.
// A write updates the shadow store. A query computes its expected density
// right away and queues it. The output monitor pops the oldest expectation
// for every density the block hands over and compares the two.
//
// The store has no reset value, so a query must never touch a voxel that was
// never written. The corners that can be fetched always lie at linear
// addresses below size_x * size_y * size_z, whatever the point. So each phase
// first fills every address below that product that is still unwritten.
// After that, queries may use any point, and writes may go anywhere.
module voxel_trilinear_sampler_test;
    import vts_pkg::*;

    // One clock is 2 ns. The run is cut off well beyond the slowest legal run.
    localparam int CYCLE_LIMIT     = 600000;
    // Cycles to let the query pipeline settle once the last result is in.
    localparam int SETTLE_CYCLES   = 12;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int HOLD_CYCLES     = 300;

    // Index 3 decodes to no register; a write to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    // Handy query coordinates in Q0.16.
    localparam logic [COORD_BITS-1:0] PT_ZERO    = 17'd0;
    localparam logic [COORD_BITS-1:0] PT_QUARTER = 17'd16384;
    localparam logic [COORD_BITS-1:0] PT_HALF    = 17'd32768;
    localparam logic [COORD_BITS-1:0] PT_3QUART  = 17'd49152;
    localparam logic [COORD_BITS-1:0] PT_ONE     = 17'd65536;
    localparam logic [COORD_BITS-1:0] PT_MAX     = 17'h1FFFF;

    typedef enum {PACE_NONE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    typedef struct {
        logic                    op;
        logic [ADDR_BITS-1:0]    vidx;
        logic [VALUE_BITS-1:0]   vval;
        logic [COORD_BITS-1:0]   px;
        logic [COORD_BITS-1:0]   py;
        logic [COORD_BITS-1:0]   pz;
    } vox_item_t;

    // One line of the directed table: a register write or a transaction,
    // with a typed-in density where the answer is obvious.
    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [SIZE_BITS-1:0]     reg_val;
        vox_item_t                item;
        bit                       typed;
        logic [DENS_BITS-1:0]     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    vts_cfg_if cfg_ch ();
    vts_in_if  in_ch ();
    vts_out_if out_ch ();

    voxel_trilinear_sampler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow state of the block.
    logic [VALUE_BITS-1:0] shadow_voxels [STORE_DEPTH];
    bit                    voxel_written [STORE_DEPTH];
    logic [SIZE_BITS-1:0]  grid_x = SIZE_RESET;
    logic [SIZE_BITS-1:0]  grid_y = SIZE_RESET;
    logic [SIZE_BITS-1:0]  grid_z = SIZE_RESET;

    // Densities still owed by the block, oldest first.
    logic [DENS_BITS-1:0]  density_q [$];

    int errors        = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    stim_row_t directed_rows [$];

    // Sizes per random phase. Zero acts as one and anything above 32 as 32,
    // so both of those cases show up here next to the true extremes.
    int phase_dims [NUM_PHASES][3] = '{
        '{1, 1, 1}, '{0, 5, 3}, '{32, 1, 2}, '{1, 32, 3}, '{3, 2, 32},
        '{63, 4, 1}, '{7, 6, 5}, '{33, 2, 1}, '{4, 4, 4}, '{5, 0, 63}
    };

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int eff_size(input logic [SIZE_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Scale p by n, take away one half and split into a signed cell index and
    // a fraction. One whole unit is added first so the shift never sees a
    // negative number, and then taken back off the cell.
    function automatic void split_axis(input logic [COORD_BITS-1:0] p, input int n,
                                       output int cell_idx, output longint frac);
        longint t;
        t = longint'(p) * n + 32768;
        frac = (t & 'hFFFF) << (FRAC_BITS - 16);
        cell_idx = int'(t >>> 16) - 1;
    endfunction

    function automatic longint voxel_at(input int x, input int y, input int z,
                                        input int nx, input int ny, input int nz);
        if (x < 0 || x >= nx || y < 0 || y >= ny || z < 0 || z >= nz) return 0;
        return longint'(shadow_voxels[(z * ny + y) * nx + x]);
    endfunction

    // The arithmetic shift of a signed product is the floor the block uses.
    function automatic longint lerp(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> FRAC_BITS);
    endfunction

    function automatic logic [DENS_BITS-1:0] interp_density(
        input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
        input logic [COORD_BITS-1:0] pz);
        int     nx, ny, nz, cx, cy, cz, dx, dy, dz;
        longint fx, fy, fz, c00, c10, c01, c11, c0, c1, r;
        longint corner [2][2][2];
        nx = eff_size(grid_x);
        ny = eff_size(grid_y);
        nz = eff_size(grid_z);
        split_axis(px, nx, cx, fx);
        split_axis(py, ny, cy, fy);
        split_axis(pz, nz, cz, fz);
        for (dz = 0; dz < 2; dz++)
            for (dy = 0; dy < 2; dy++)
                for (dx = 0; dx < 2; dx++)
                    corner[dz][dy][dx] = voxel_at(cx + dx, cy + dy, cz + dz, nx, ny, nz);
        c00 = lerp(corner[0][0][0], corner[0][0][1], fx);
        c10 = lerp(corner[0][1][0], corner[0][1][1], fx);
        c01 = lerp(corner[1][0][0], corner[1][0][1], fx);
        c11 = lerp(corner[1][1][0], corner[1][1][1], fx);
        c0  = lerp(c00, c10, fy);
        c1  = lerp(c01, c11, fy);
        r   = lerp(c0, c1, fz);
        if (r < 0) r = 0;
        return DENS_BITS'(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [SIZE_BITS-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic stim_row_t wr_row(input logic [ADDR_BITS-1:0] idx,
                                         input logic [VALUE_BITS-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.item.op   = OP_WRITE;
        row.item.vidx = idx;
        row.item.vval = val;
        return row;
    endfunction

    function automatic stim_row_t qry_row(input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y,
                                          input logic [COORD_BITS-1:0] z);
        stim_row_t row;
        row = '{default: '0};
        row.item.op = OP_QUERY;
        row.item.px = x;
        row.item.py = y;
        row.item.pz = z;
        return row;
    endfunction

    function automatic stim_row_t qry_known(input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y,
                                            input logic [COORD_BITS-1:0] z,
                                            input logic [DENS_BITS-1:0] want);
        stim_row_t row;
        row = qry_row(x, y, z);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    // Densities lean toward the rails so that steep blends come up often.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? '1 : '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Mostly points inside the cube, with the corners of the range and
    // points beyond one mixed in.
    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(9))
            0: return PT_ZERO;
            1: return PT_ONE;
            2: return PT_MAX;
            3: return COORD_BITS'($urandom_range(131071, 65537));
            default: return COORD_BITS'($urandom_range(65536));
        endcase
    endfunction

    // Every field is filled in; the block ignores the ones the operation
    // does not use.
    function automatic vox_item_t random_item(input int n_used);
        vox_item_t it;
        it.op   = ($urandom_range(99) < 60) ? OP_QUERY : OP_WRITE;
        it.vidx = $urandom_range(1) ? ADDR_BITS'($urandom_range(n_used - 1))
                                    : ADDR_BITS'($urandom);
        it.vval = pick_value();
        it.px   = pick_coord();
        it.py   = pick_coord();
        it.pz   = pick_coord();
        return it;
    endfunction

    task automatic set_pacing(input pace_t mode);
        case (mode)
            PACE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default: begin
                send_idle_pct  = 7;
                recv_stall_pct = 7;
            end
        endcase
    endtask

    // Offers one transaction, holding it until the block takes it, then
    // applies it to the shadow state. valid is left high so that a following
    // transaction can go back to back; it changes only at the next falling edge.
    task automatic send_item(input vox_item_t it, input bit typed,
                             input logic [DENS_BITS-1:0] want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.operation   = it.op;
        in_ch.voxel_index = it.vidx;
        in_ch.voxel_value = it.vval;
        in_ch.point_x     = it.px;
        in_ch.point_y     = it.py;
        in_ch.point_z     = it.pz;
        in_ch.valid       = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (it.op == OP_WRITE) begin
            shadow_voxels[it.vidx] = it.vval;
            voxel_written[it.vidx] = 1'b1;
        end else begin
            density_q.push_back(typed ? want : interp_density(it.px, it.py, it.pz));
        end
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Waits for every owed density, then gives the last query time to leave
    // the pipeline.
    task automatic drain();
        idle_input();
        while (density_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size registers may only change while the block is idle.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [SIZE_BITS-1:0] val);
        drain();
        @(negedge clk);
        cfg_ch.reg_index  = idx;
        cfg_ch.write_data = val;
        cfg_ch.valid      = 1'b1;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_SIZE_X: grid_x = val;
            REG_SIZE_Y: grid_y = val;
            REG_SIZE_Z: grid_z = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls at random, or holds off completely for a stretch
    // when the main flow asks for it. The count runs here, so the sender
    // keeps offering transactions the whole time.
    always @(negedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : density_monitor
        logic [DENS_BITS-1:0] want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (density_q.size() == 0) begin
                $error("density_out %0d arrived with no result expected",
                       out_ch.density_out);
                errors++;
            end else begin
                want = density_q.pop_front();
                if (out_ch.density_out !== want) begin
                    $error("density_out mismatch: expected %0d, got %0d",
                           want, out_ch.density_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------

    initial begin
        int        ph;
        int        k;
        int        a;
        int        n_used;
        vox_item_t it;

        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = '0;
        cfg_ch.write_data = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_WRITE;
        in_ch.voxel_index = '0;
        in_ch.voxel_value = '0;
        in_ch.point_x     = '0;
        in_ch.point_y     = '0;
        in_ch.point_z     = '0;
        out_ch.ready      = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on a 2x2x2 grid. The eight voxels are written first.
        // A point at one quarter sits exactly on voxel 0 and one at three
        // quarters exactly on voxel 7. A point at zero or at one blends the
        // nearest voxel with zeros from outside the grid three times over.
        // A point far above one leaves every corner outside and gives zero.
        // The write to the unused register index must leave the sizes alone.
        directed_rows = {
            cfg_row(REG_SIZE_X, 6'd2), cfg_row(REG_SIZE_Y, 6'd2),
            cfg_row(REG_SIZE_Z, 6'd2), cfg_row(REG_UNUSED, 6'h3F),
            wr_row(15'd0, 16'hFFFF), wr_row(15'd1, 16'h1000),
            wr_row(15'd2, 16'h0000), wr_row(15'd3, 16'hFFFF),
            wr_row(15'd4, 16'h8000), wr_row(15'd5, 16'h0001),
            wr_row(15'd6, 16'h7FFF), wr_row(15'd7, 16'h8000),
            wr_row(15'h7FFF, 16'hFFFF), wr_row(15'h4000, 16'h0000),
            qry_known(PT_QUARTER, PT_QUARTER, PT_QUARTER, 16'hFFFF),
            qry_known(PT_3QUART, PT_3QUART, PT_3QUART, 16'h8000),
            qry_known(PT_ZERO, PT_ZERO, PT_ZERO, 16'd8191),
            qry_known(PT_ONE, PT_ONE, PT_ONE, 16'd4096),
            qry_known(PT_MAX, PT_MAX, PT_MAX, 16'd0),
            qry_known(PT_MAX, PT_QUARTER, PT_QUARTER, 16'd0),
            qry_row(PT_HALF, PT_HALF, PT_HALF),
            qry_row(17'h0FFFF, PT_ZERO, PT_ONE),
            qry_row(17'd1, 17'h0FFFF, PT_HALF),
            qry_row(17'd12345, 17'd54321, 17'd40000),
            qry_row(17'h10001, 17'h0AAAA, 17'h05555)
        };

        set_pacing(PACE_NONE);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // Random phases, each on its own grid and with its own pacing.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_register(REG_SIZE_X, SIZE_BITS'(phase_dims[ph][0]));
            write_register(REG_SIZE_Y, SIZE_BITS'(phase_dims[ph][1]));
            write_register(REG_SIZE_Z, SIZE_BITS'(phase_dims[ph][2]));
            set_pacing(pace_t'(ph % 4));
            n_used = eff_size(grid_x) * eff_size(grid_y) * eff_size(grid_z);

            // Fill whatever part of the grid in use has not been written yet,
            // so that no corner fetch can hit an unwritten voxel.
            for (a = 0; a < n_used; a++) begin
                if (!voxel_written[a]) begin
                    it      = random_item(n_used);
                    it.op   = OP_WRITE;
                    it.vidx = ADDR_BITS'(a);
                    send_item(it, 1'b0, '0);
                end
            end

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // A long hold-off on the result side fills the output queue
                // and must stall the input side.
                if (k == 20 && (ph == 3 || ph == 8))
                    hold_req = HOLD_CYCLES;
                // Once, the sender stops until every result has come back.
                if (k == 40 && ph == 6) begin
                    idle_input();
                    while (density_q.size() != 0) @(posedge clk);
                end
                send_item(random_item(n_used), 1'b0, '0);
            end
        end

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
